// ===== rtl/core/bb3_pkg.sv =====
// Shared widths, codes and handshake types for the 3x3 box blur.
`default_nettype none
package bb3_pkg;
  localparam int PIX_W  = 8;
  localparam int RGB_W  = 3 * PIX_W;
  localparam int CFG_W  = 11;
  localparam int SUM_W  = 12;
  localparam int NUM_W  = 13;
  localparam int CNT_W  = 4;
  localparam int QDIV_W = 5;
  localparam int CFG_IDX_W = 2;

  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 1024;

  localparam logic [CFG_W-1:0] CFG_RESET = 11'd1024;

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;

  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_DRAIN = 1'b1;

  typedef logic [PIX_W-1:0] chan_t;
  typedef logic [NUM_W-1:0] num_t;

  typedef struct packed {
    logic              start;
    logic [QDIV_W-1:0] divisor;
  } div_req_t;
endpackage
`default_nettype wire

// ===== rtl/core/bb3_div.sv =====
// Iterative restoring divider for the three color channels, one quotient bit per cycle.
`default_nettype none
module bb3_div
  import bb3_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  div_req_t      req_i,
  input  num_t  [2:0]   num_i,
  output logic          done_o,
  output chan_t [2:0]   quo_o
);
  logic              busy_q;
  logic [2:0]        step_q;
  logic              done_q;
  logic [QDIV_W-1:0] div_q;
  num_t  [2:0]       rem_q, rem_d;
  chan_t [2:0]       quo_q, quo_d;
  num_t              shifted;

  always_comb begin
    shifted = num_t'(div_q) << step_q;
    rem_d   = rem_q;
    quo_d   = quo_q;
    for (int ch = 0; ch < 3; ch++) begin
      if (rem_q[ch] >= shifted) begin
        rem_d[ch]         = rem_q[ch] - shifted;
        quo_d[ch][step_q] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        step_q <= 3'd7;
      end else if (busy_q) begin
        step_q <= step_q - 3'd1;
        if (step_q == 3'd0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      div_q <= req_i.divisor;
      rem_q <= num_i;
      quo_q <= '0;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;
endmodule
`default_nettype wire

// ===== rtl/core/box_blur_3x3_edge_aware_top.sv =====
// Top level of the streaming 3x3 edge-aware box blur with its line memory.
//
//   channel | direction | handshake             | payload
//   --------+-----------+-----------------------+----------------------------------
//   input   | in        | in_valid_i/in_stall_o | command_i, in_red/green/blue_i
//   output  | out       | out_valid_o/out_stall_i | out_red/green/blue_o, frame_last_o
//   config  | in        | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// A beat that yields a pixel passes a line memory read, a read-modify-write step, eight
// divider steps and their done flag, and an output load. A beat without output stops
// after the read-modify-write, which repeats for the last pixel of a one-row frame.
// The line memory has no reset; entries never written are masked at the frame edge.
// A full output register stalls the block only when the next pixel is ready to load.
`default_nettype none
module box_blur_3x3_edge_aware_top
  import bb3_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic                 command_i,
  input  logic [PIX_W-1:0]     in_red_i,
  input  logic [PIX_W-1:0]     in_green_i,
  input  logic [PIX_W-1:0]     in_blue_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [PIX_W-1:0]     out_red_o,
  output logic [PIX_W-1:0]     out_green_o,
  output logic [PIX_W-1:0]     out_blue_o,
  output logic                 frame_last_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]     cfg_data_i
);
  localparam int CW   = $clog2(MAX_WIDTH);
  localparam int RW   = $clog2(MAX_HEIGHT) + 2;
  localparam int PW   = $clog2(MAX_WIDTH + 2);
  localparam int MAXD = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
  localparam int DW   = ($clog2(MAXD) + 3 > CFG_W + 1) ? $clog2(MAXD) + 3 : CFG_W + 1;
  localparam int MW   = 2 * RGB_W;

  typedef enum logic [1:0] {ST_IDLE, ST_ADV, ST_DIV, ST_OUT} st_e;

  st_e               state_q;
  logic [CFG_W-1:0]  cfg_w_q, cfg_h_q;
  logic [DW-1:0]     eff_w, eff_h;
  logic [CW-1:0]     in_col_q, out_col_q;
  logic [RW-1:0]     in_row_q, out_row_q;
  logic [PW-1:0]     pend_q;
  logic              fc_q;
  logic [RGB_W-1:0]  win_q [6];
  logic [RGB_W-1:0]  act_pix_q;
  logic              act_emit_q, act_drain_q, act_last_q, act_extra_q;
  logic              last_q;
  logic              out_valid_q, frame_last_q;
  chan_t [2:0]       out_q;

  logic [MW-1:0]     mem [MAX_WIDTH];
  logic [MW-1:0]     mem_rd_q, fwd_data_q;
  logic              fwd_q;
  logic              mem_re, mem_we;
  logic [CW-1:0]     mem_ra, mem_wa;
  logic [MW-1:0]     mem_wd, rd;

  logic              in_acc, start_pix, start_drn, acc_last, acc_emit;
  logic [RGB_W-1:0]  colv [3];
  logic [RGB_W-1:0]  p;
  logic [2:0]        cvv, rvv;
  logic [SUM_W-1:0]  sum [3];
  logic [CNT_W-1:0]  cnt;
  logic [DW-1:0]     in_col_inc, out_col_inc;
  logic              in_wrap, out_wrap;
  logic [CW-1:0]     nxt_col;
  logic [PW-1:0]     pend_inc, pend_dec;
  logic              extra_go, drain_end;
  div_req_t          div_req;
  num_t  [2:0]       div_num;
  logic              div_done;
  chan_t [2:0]       div_quo;

  always_comb begin
    if (cfg_w_q == '0) begin
      eff_w = DW'(1);
    end else if (DW'(cfg_w_q) > DW'(MAX_WIDTH)) begin
      eff_w = DW'(MAX_WIDTH);
    end else begin
      eff_w = DW'(cfg_w_q);
    end
    if (cfg_h_q == '0) begin
      eff_h = DW'(1);
    end else if (DW'(cfg_h_q) > DW'(MAX_HEIGHT)) begin
      eff_h = DW'(MAX_HEIGHT);
    end else begin
      eff_h = DW'(cfg_h_q);
    end
  end

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_acc      = in_valid_i & ~in_stall_o;
  assign start_pix   = in_acc & (command_i == CMD_PIXEL) & ~fc_q;
  assign start_drn   = in_acc & (command_i == CMD_DRAIN) & fc_q & (pend_q != '0);
  assign acc_last    = (DW'(in_row_q) + DW'(1) >= eff_h) && (DW'(in_col_q) + DW'(1) >= eff_w);
  assign acc_emit    = DW'(pend_q) >= eff_w + DW'(1);

  assign rd      = fwd_q ? fwd_data_q : mem_rd_q;
  assign colv[0] = rd[MW-1:RGB_W];
  assign colv[1] = rd[RGB_W-1:0];
  assign colv[2] = act_pix_q;

  assign in_col_inc  = DW'(in_col_q) + DW'(1);
  assign in_wrap     = in_col_inc >= eff_w;
  assign nxt_col     = in_wrap ? '0 : in_col_inc[CW-1:0];
  assign out_col_inc = DW'(out_col_q) + DW'(1);
  assign out_wrap    = out_col_inc >= eff_w;
  assign pend_inc    = pend_q + PW'(1);
  assign pend_dec    = pend_q - PW'(1);
  assign drain_end   = (pend_dec == '0);
  assign extra_go    = (state_q == ST_ADV) && !act_drain_q && !act_extra_q && act_last_q &&
                       (DW'(act_emit_q ? pend_q : pend_inc) <= eff_w);

  always_comb begin
    cvv[0] = (out_col_q != '0);
    cvv[1] = 1'b1;
    cvv[2] = out_col_inc < eff_w;
    rvv[0] = (out_row_q != '0);
    rvv[1] = 1'b1;
    rvv[2] = DW'(out_row_q) + DW'(1) < eff_h;
    cnt    = '0;
    p      = '0;
    for (int ch = 0; ch < 3; ch++) begin
      sum[ch] = '0;
    end
    for (int x = 0; x < 3; x++) begin
      for (int y = 0; y < 3; y++) begin
        p = (x == 2) ? colv[y] : win_q[x * 3 + y];
        if (cvv[x] && rvv[y]) begin
          cnt = cnt + CNT_W'(1);
          for (int ch = 0; ch < 3; ch++) begin
            sum[ch] = sum[ch] + SUM_W'(p[RGB_W-1-PIX_W*ch -: PIX_W]);
          end
        end
      end
    end
    for (int ch = 0; ch < 3; ch++) begin
      div_num[ch] = NUM_W'({sum[ch], 1'b0}) + NUM_W'(cnt);
    end
    div_req.start   = (state_q == ST_ADV) && act_emit_q;
    div_req.divisor = QDIV_W'({cnt, 1'b0});
  end

  always_comb begin
    mem_re = 1'b0;
    mem_ra = in_col_q;
    mem_we = 1'b0;
    mem_wa = in_col_q;
    mem_wd = {colv[1], act_pix_q};
    if (state_q == ST_IDLE) begin
      mem_re = start_pix | start_drn;
    end else if (state_q == ST_ADV) begin
      mem_we = 1'b1;
      mem_re = extra_go;
      mem_ra = nxt_col;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      mem_rd_q <= mem[mem_ra];
    end
    fwd_data_q <= mem_wd;
  end

  bb3_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .num_i  (div_num),
    .done_o (div_done),
    .quo_o  (div_quo)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      cfg_w_q      <= CFG_RESET;
      cfg_h_q      <= CFG_RESET;
      in_col_q     <= '0;
      in_row_q     <= '0;
      out_col_q    <= '0;
      out_row_q    <= '0;
      pend_q       <= '0;
      fc_q         <= 1'b0;
      for (int i = 0; i < 6; i++) begin
        win_q[i] <= '0;
      end
      act_pix_q    <= '0;
      act_emit_q   <= 1'b0;
      act_drain_q  <= 1'b0;
      act_last_q   <= 1'b0;
      act_extra_q  <= 1'b0;
      last_q       <= 1'b0;
      out_valid_q  <= 1'b0;
      frame_last_q <= 1'b0;
      out_q        <= '0;
      fwd_q        <= 1'b0;
    end else begin
      fwd_q <= mem_re & mem_we & (mem_ra == mem_wa);
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == CFG_FRAME_WIDTH) begin
          cfg_w_q <= cfg_data_i;
        end else if (cfg_index_i == CFG_FRAME_HEIGHT) begin
          cfg_h_q <= cfg_data_i;
        end
      end
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (start_pix || start_drn) begin
            act_pix_q   <= start_drn ? '0 : {in_red_i, in_green_i, in_blue_i};
            act_emit_q  <= start_drn | acc_emit;
            act_drain_q <= start_drn;
            act_last_q  <= start_pix & acc_last;
            act_extra_q <= 1'b0;
            state_q     <= ST_ADV;
          end
        end
        ST_ADV: begin
          for (int i = 0; i < 3; i++) begin
            win_q[i]     <= win_q[i + 3];
            win_q[i + 3] <= colv[i];
          end
          in_col_q <= nxt_col;
          if (in_wrap) begin
            in_row_q <= in_row_q + RW'(1);
          end
          if (act_emit_q) begin
            out_col_q <= out_wrap ? '0 : out_col_inc[CW-1:0];
            if (out_wrap) begin
              out_row_q <= out_row_q + RW'(1);
            end
          end
          if (act_drain_q) begin
            pend_q  <= pend_dec;
            last_q  <= drain_end;
            state_q <= ST_DIV;
            if (drain_end) begin
              in_col_q  <= '0;
              in_row_q  <= '0;
              out_col_q <= '0;
              out_row_q <= '0;
              fc_q      <= 1'b0;
            end
          end else if (act_extra_q) begin
            act_extra_q <= 1'b0;
            state_q     <= ST_IDLE;
          end else begin
            last_q <= 1'b0;
            if (!act_emit_q) begin
              pend_q <= pend_inc;
            end
            if (act_last_q) begin
              fc_q <= 1'b1;
            end
            if (extra_go) begin
              act_extra_q <= 1'b1;
              act_pix_q   <= '0;
              act_emit_q  <= 1'b0;
              state_q     <= ST_ADV;
            end else if (act_emit_q) begin
              state_q <= ST_DIV;
            end else begin
              state_q <= ST_IDLE;
            end
          end
        end
        ST_DIV: begin
          if (div_done) begin
            state_q <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (!out_valid_q || !out_stall_i) begin
            out_q        <= div_quo;
            frame_last_q <= last_q;
            out_valid_q  <= 1'b1;
            state_q      <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_red_o    = out_q[0];
  assign out_green_o  = out_q[1];
  assign out_blue_o   = out_q[2];
  assign frame_last_o = frame_last_q;

`ifndef SYNTHESIS
  a_div_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == ST_DIV)
    else $error("Divider finished outside the divide phase.");
  a_fc_pend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fc_q |-> pend_q != '0)
    else $error("Frame complete with no pending output.");
  a_emit_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ADV && act_emit_q) |=> state_q == ST_DIV)
    else $error("Emitting beat did not enter the divide phase.");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_OUT && out_valid_q && out_stall_i) |=> state_q == ST_OUT)
    else $error("Output register overwritten while stalled.");
  a_pend_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    DW'(pend_q) <= DW'(MAX_WIDTH) + DW'(1))
    else $error("Pending count beyond one row plus one.");
`endif
endmodule
`default_nettype wire

// ===== verif/tb_box_blur_3x3_edge_aware_top.sv =====
// Self-checking testbench for the streaming 3x3 edge-aware box blur top level.
`timescale 1ns / 100ps

module tb_box_blur_3x3_edge_aware_top;
  import bb3_pkg::*;

  localparam int LINE_DEPTH = DEF_MAX_WIDTH;
  localparam int ROW_LIMIT  = DEF_MAX_HEIGHT;
  localparam int SETTLE_CYCLES = 30;
  localparam int STALL_LIMIT = 5000;
  localparam int RANDOM_ITEMS = 1150;

  typedef struct packed {
    chan_t red;
    chan_t green;
    chan_t blue;
    logic  last;
  } blur_pixel_t;

  class blur_scoreboard;
    logic [RGB_W-1:0] upper_line [LINE_DEPTH];
    logic [RGB_W-1:0] middle_line [LINE_DEPTH];
    logic [RGB_W-1:0] window [6];
    int unsigned in_row, in_col, out_row, out_col, pending;
    bit frame_done;
    int unsigned width_reg, height_reg;
    blur_pixel_t expected_pixels[$];
    int errors;

    function new();
      foreach (upper_line[i]) begin
        upper_line[i] = '0;
        middle_line[i] = '0;
      end
      foreach (window[i]) window[i] = '0;
      in_row = 0; in_col = 0; out_row = 0; out_col = 0; pending = 0;
      frame_done = 0;
      width_reg = CFG_RESET;
      height_reg = CFG_RESET;
      errors = 0;
    endfunction

    function int unsigned active_width();
      if (width_reg < 1) return 1;
      if (width_reg > LINE_DEPTH) return LINE_DEPTH;
      return width_reg;
    endfunction

    function int unsigned active_height();
      if (height_reg < 1) return 1;
      if (height_reg > ROW_LIMIT) return ROW_LIMIT;
      return height_reg;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
      if (idx == CFG_FRAME_WIDTH) width_reg = data;
      else if (idx == CFG_FRAME_HEIGHT) height_reg = data;
    endfunction

    function void shift_column(logic [RGB_W-1:0] pix, bit emit, output blur_pixel_t px);
      int unsigned w, h, c, cnt;
      int unsigned sums [3];
      logic [RGB_W-1:0] column [3];
      logic [RGB_W-1:0] p;
      bit row_ok [3];
      bit col_ok [3];
      w = active_width();
      h = active_height();
      c = (in_col >= LINE_DEPTH) ? 0 : in_col;
      column[0] = upper_line[c];
      column[1] = middle_line[c];
      column[2] = pix;
      upper_line[c] = middle_line[c];
      middle_line[c] = pix;
      px = '0;
      if (emit) begin
        row_ok[0] = out_row >= 1; row_ok[1] = 1; row_ok[2] = out_row + 1 < h;
        col_ok[0] = out_col >= 1; col_ok[1] = 1; col_ok[2] = out_col + 1 < w;
        sums[0] = 0; sums[1] = 0; sums[2] = 0;
        cnt = 0;
        for (int x = 0; x < 3; x++) begin
          for (int y = 0; y < 3; y++) begin
            if (col_ok[x] && row_ok[y]) begin
              p = (x == 2) ? column[y] : window[x * 3 + y];
              sums[0] += 32'(p[23:16]);
              sums[1] += 32'(p[15:8]);
              sums[2] += 32'(p[7:0]);
              cnt++;
            end
          end
        end
        px.red   = chan_t'((2 * sums[0] + cnt) / (2 * cnt));
        px.green = chan_t'((2 * sums[1] + cnt) / (2 * cnt));
        px.blue  = chan_t'((2 * sums[2] + cnt) / (2 * cnt));
        out_col++;
        if (out_col >= w) begin
          out_col = 0;
          out_row++;
        end
      end
      window[0] = window[3]; window[1] = window[4]; window[2] = window[5];
      window[3] = column[0]; window[4] = column[1]; window[5] = column[2];
      in_col++;
      if (in_col >= w) begin
        in_col = 0;
        in_row++;
      end
    endfunction

    // Returns 1 when the beat did something, 0 when the block ignores it.
    function bit note_input(logic cmd, chan_t r, chan_t g, chan_t b);
      blur_pixel_t px;
      blur_pixel_t unused;
      int unsigned w, h;
      bit last_pixel, emit;
      w = active_width();
      h = active_height();
      if (cmd == CMD_PIXEL) begin
        if (frame_done) return 0;
        last_pixel = (in_row + 1 >= h) && (in_col + 1 >= w);
        emit = pending >= w + 1;
        shift_column({r, g, b}, emit, px);
        if (emit) expected_pixels.push_back(px);
        else pending++;
        if (last_pixel) begin
          frame_done = 1;
          if (pending <= w) shift_column('0, 0, unused);
        end
        return 1;
      end
      if (!frame_done || pending == 0) return 0;
      shift_column('0, 1, px);
      pending--;
      if (pending == 0) begin
        px.last = 1;
        in_row = 0; in_col = 0; out_row = 0; out_col = 0;
        frame_done = 0;
      end
      expected_pixels.push_back(px);
      return 1;
    endfunction

    task report_mismatch(string what);
      $display("ERROR %0t: %s", $realtime, what);
      errors++;
    endtask

    task check_output(chan_t r, chan_t g, chan_t b, logic last);
      blur_pixel_t exp_px;
      if (expected_pixels.size() == 0) begin
        report_mismatch($sformatf("unexpected pixel %h %h %h last %b", r, g, b, last));
        return;
      end
      exp_px = expected_pixels.pop_front();
      if (r !== exp_px.red)
        report_mismatch($sformatf("red %h, expected %h", r, exp_px.red));
      if (g !== exp_px.green)
        report_mismatch($sformatf("green %h, expected %h", g, exp_px.green));
      if (b !== exp_px.blue)
        report_mismatch($sformatf("blue %h, expected %h", b, exp_px.blue));
      if (last !== exp_px.last)
        report_mismatch($sformatf("frame_last %b, expected %b", last, exp_px.last));
    endtask
  endclass

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid_i = 1'b0;
  logic                 in_stall_o;
  logic                 command_i = CMD_PIXEL;
  logic [PIX_W-1:0]     in_red_i = '0;
  logic [PIX_W-1:0]     in_green_i = '0;
  logic [PIX_W-1:0]     in_blue_i = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  logic [PIX_W-1:0]     out_red_o;
  logic [PIX_W-1:0]     out_green_o;
  logic [PIX_W-1:0]     out_blue_o;
  logic                 frame_last_o;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [CFG_W-1:0]     cfg_data_i = '0;

  blur_scoreboard blur_sb = new();
  int sender_idle_pct = 0;
  int receiver_stall_pct = 0;
  int busy_items = 0;
  int quiet_cycles = 0;

  box_blur_3x3_edge_aware_top uut (.*);

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i)
        blur_sb.check_output(out_red_o, out_green_o, out_blue_o, frame_last_o);
      out_stall_i <= ($urandom_range(99) < receiver_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o) || !rst_ni) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_beat(logic cmd, chan_t r, chan_t g, chan_t b);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    command_i  <= cmd;
    in_red_i   <= r;
    in_green_i <= g;
    in_blue_i  <= b;
    do @(posedge clk_i); while (in_stall_o);
    if (blur_sb.note_input(cmd, r, g, b)) busy_items++;
  endtask

  task automatic send_pixel(bit extremes);
    if (extremes)
      send_beat(CMD_PIXEL, $urandom_range(1) ? 8'hff : 8'h00,
                $urandom_range(1) ? 8'hff : 8'h00, $urandom_range(1) ? 8'hff : 8'h00);
    else
      send_beat(CMD_PIXEL, chan_t'($urandom), chan_t'($urandom), chan_t'($urandom));
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (blur_sb.expected_pixels.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    blur_sb.write_reg(idx, data);
  endtask

  task automatic set_frame(int w, int h);
    wait_idle();
    write_reg(CFG_FRAME_WIDTH, CFG_W'(w));
    write_reg(CFG_FRAME_HEIGHT, CFG_W'(h));
  endtask

  // Streams pixels until the frame is full, then drains it; noise_pct adds stray beats.
  task automatic finish_frame(bit extremes, int noise_pct);
    while (!blur_sb.frame_done) begin
      if ($urandom_range(99) < noise_pct)
        send_beat(CMD_DRAIN, chan_t'($urandom), chan_t'($urandom), chan_t'($urandom));
      send_pixel(extremes);
    end
    while (blur_sb.frame_done) begin
      if ($urandom_range(99) < noise_pct) send_pixel(0);
      send_beat(CMD_DRAIN, chan_t'($urandom), chan_t'($urandom), chan_t'($urandom));
    end
  endtask

  initial begin
    int w, h;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    set_frame(1, 1);
    send_beat(CMD_DRAIN, 8'hff, 8'hff, 8'hff);
    send_beat(CMD_PIXEL, 8'hff, 8'h00, 8'hff);
    send_beat(CMD_PIXEL, 8'h00, 8'hff, 8'h00);
    send_beat(CMD_DRAIN, 8'h00, 8'h00, 8'h00);
    send_beat(CMD_DRAIN, 8'h00, 8'h00, 8'h00);
    set_frame(3, 3);
    finish_frame(1, 0);
    set_frame(1, 3);
    finish_frame(1, 0);
    set_frame(3, 1);
    finish_frame(1, 0);

    set_frame(5, 4);
    repeat (8) send_pixel(1);
    wait_idle();
    write_reg(CFG_FRAME_WIDTH, CFG_W'(3));
    finish_frame(1, 0);

    set_frame(0, 2047);
    repeat (6) send_pixel(0);
    wait_idle();
    write_reg(CFG_FRAME_HEIGHT, CFG_W'(3));
    finish_frame(0, 0);
    set_frame(2047, 0);
    repeat (6) send_pixel(0);
    wait_idle();
    write_reg(CFG_FRAME_WIDTH, CFG_W'(4));
    finish_frame(0, 0);

    busy_items = 0;
    while (busy_items < RANDOM_ITEMS) begin
      case ((busy_items * 4) / RANDOM_ITEMS)
        0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
        1: begin sender_idle_pct = 56; receiver_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  receiver_stall_pct = 56; end
        default: begin sender_idle_pct = 26; receiver_stall_pct = 26; end
      endcase
      if ($urandom_range(9) == 0) begin
        w = $urandom_range(1, 40);
        h = $urandom_range(0, 3);
      end else begin
        w = $urandom_range(1, 8);
        h = $urandom_range(1, 6);
      end
      if ($urandom_range(1)) set_frame(w, h);
      if ($urandom_range(19) == 0) begin
        repeat ($urandom_range(1, 6)) send_pixel(0);
        wait_idle();
        if (!blur_sb.frame_done)
          write_reg(CFG_FRAME_WIDTH, CFG_W'($urandom_range(1, 8)));
      end
      finish_frame($urandom_range(4) == 0, 5);
    end

    wait_idle();
    if (blur_sb.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
